// ----- hw/rtl/bot_pkg.sv -----
// Package for the bulk-only transport command engine.
// Holds request/result codes, opcodes and the beat structs; no dependencies.
`default_nettype none

package bot_pkg;

    localparam int unsigned MAX_BLOCK_SIZE = 4096;

    localparam logic [2:0] REQ_RW       = 3'd0;
    localparam logic [2:0] REQ_PROBE    = 3'd1;
    localparam logic [2:0] REQ_CAPQUERY = 3'd2;
    localparam logic [2:0] REQ_CAPREPLY = 3'd3;
    localparam logic [2:0] REQ_RECEIPT  = 3'd4;

    localparam logic [2:0] RES_REFUSED     = 3'd0;
    localparam logic [2:0] RES_ENVELOPE    = 3'd1;
    localparam logic [2:0] RES_GOOD        = 3'd2;
    localparam logic [2:0] RES_FAILED      = 3'd3;
    localparam logic [2:0] RES_CAP_TAKEN   = 3'd4;
    localparam logic [2:0] RES_CAP_REFUSED = 3'd5;

    localparam logic [1:0] PK_SENSE = 2'd0;
    localparam logic [1:0] PK_RW    = 2'd1;
    localparam logic [1:0] PK_PROBE = 2'd2;
    localparam logic [1:0] PK_CAP   = 2'd3;

    localparam logic [7:0] OP_PROBE    = 8'h00;
    localparam logic [7:0] OP_SENSE    = 8'h03;
    localparam logic [7:0] OP_CAPACITY = 8'h25;
    localparam logic [7:0] OP_READ10   = 8'h28;
    localparam logic [7:0] OP_WRITE10  = 8'h2A;

    localparam logic [4:0] CMD_LEN_6  = 5'd6;
    localparam logic [4:0] CMD_LEN_10 = 5'd10;

    localparam logic [31:0] RECEIPT_SIG    = 32'h5342_5355;
    localparam logic [31:0] LAST_BLOCK_MAX = 32'hFFFF_FFFF;
    localparam logic [27:0] SENSE_BYTES    = 28'd18;
    localparam logic [27:0] CAP_BYTES      = 28'd8;
    localparam int unsigned SECTOR_SIZE_DEFAULT = 512;

    localparam logic [2:0] REG_ATTACHED = 3'd0;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        is_write;
        logic [31:0] block_addr;
        logic [31:0] block_count;
        logic [31:0] reply_last_block;
        logic [31:0] reply_block_size;
        logic [31:0] receipt_signature;
        logic [31:0] receipt_tag;
        logic [7:0]  receipt_status;
        logic        receipt_complete;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] env_tag;
        logic [27:0] env_data_length;
        logic        env_data_in;
        logic [7:0]  env_opcode;
        logic [31:0] env_block_addr;
        logic [15:0] env_block_count;
        logic [4:0]  env_cmd_len;
        logic        last_of_run;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/bot_req_if.sv -----
// Request channel interface of the bulk-only transport command engine.
// Valid/ready handshake with the input item fields; no dependencies.
`default_nettype none

interface bot_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic        is_write;
    logic [31:0] block_addr;
    logic [31:0] block_count;
    logic [31:0] reply_last_block;
    logic [31:0] reply_block_size;
    logic [31:0] receipt_signature;
    logic [31:0] receipt_tag;
    logic [7:0]  receipt_status;
    logic        receipt_complete;

    modport source (
        output valid, req_type, is_write, block_addr, block_count, reply_last_block,
               reply_block_size, receipt_signature, receipt_tag, receipt_status,
               receipt_complete,
        input  ready
    );
    modport sink (
        input  valid, req_type, is_write, block_addr, block_count, reply_last_block,
               reply_block_size, receipt_signature, receipt_tag, receipt_status,
               receipt_complete,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/bot_res_if.sv -----
// Result channel interface of the bulk-only transport command engine.
// Valid/ready handshake with the result fields; no dependencies.
`default_nettype none

interface bot_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [31:0] env_tag;
    logic [27:0] env_data_length;
    logic        env_data_in;
    logic [7:0]  env_opcode;
    logic [31:0] env_block_addr;
    logic [15:0] env_block_count;
    logic [4:0]  env_cmd_len;
    logic        last_of_run;

    modport source (
        output valid, result_kind, env_tag, env_data_length, env_data_in, env_opcode,
               env_block_addr, env_block_count, env_cmd_len, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, result_kind, env_tag, env_data_length, env_data_in, env_opcode,
               env_block_addr, env_block_count, env_cmd_len, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/usb_bulk_only_scsi_command_engine_top.sv -----
// Bulk-only transport command engine (host side), top level.
// Depends on bot_pkg, bot_req_if and bot_res_if.
//
// One request, capacity reply or receipt is taken per cycle and decided in a
// single pass between the input register and the result register, so a new
// item is accepted every clock as long as the result side keeps taking beats.
// A failed read, write or probe (device still attached) gives two beats (failed
// verdict, then the request-sense envelope); the second beat is held in an extra
// result register, and input stalls until it has moved to the result register.
// The item is held in the input register, then its first result beat in the result
// register. The only register, device_attached at byte address 0, is written over
// the APB port; any write to it drops the known capacity and any outstanding command.
`default_nettype none

module usb_bulk_only_scsi_command_engine_top #(
    parameter int unsigned P_MAX_BLOCK_SIZE = bot_pkg::MAX_BLOCK_SIZE
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bot_req_if.sink     i_req,
    bot_res_if.source   o_res,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import bot_pkg::*;

    localparam int unsigned SW = $clog2(P_MAX_BLOCK_SIZE + 1);

    logic          r_in_v;
    t_req          r_in;
    logic          r_o_v;
    t_result       r_o;
    logic          r_x_v;
    t_result       r_x;

    logic          r_attached, n_attached;
    logic [31:0]   r_tag_seq, n_tag_seq;
    logic          r_busy, n_busy;
    logic [1:0]    r_pend_kind, n_pend_kind;
    logic [31:0]   r_pend_tag, n_pend_tag;
    logic [31:0]   r_sector_count, n_sector_count;
    logic [SW-1:0] r_sector_size, n_sector_size;

    t_result       res0, res1;
    logic          two;
    logic          slot_free, fire, in_acc, cfg_wr;
    logic [32:0]   end_sum;
    logic [SW+15:0] prod;
    logic          receipt_ok;

    assign cfg_wr    = i_psel & i_penable & i_pwrite & (i_paddr[2] == REG_ATTACHED[0]);
    assign o_pready  = 1'b1;
    assign o_prdata  = (i_paddr[2] == REG_ATTACHED[0]) ? {31'd0, r_attached} : 32'd0;

    assign slot_free = !r_o_v || o_res.ready;
    assign fire      = r_in_v && slot_free && !r_x_v;
    assign i_req.ready = !r_in_v || fire;
    assign in_acc    = i_req.valid && i_req.ready;

    assign end_sum    = {1'b0, r_in.block_addr} + {1'b0, r_in.block_count};
    assign prod       = r_in.block_count[15:0] * r_sector_size;
    assign receipt_ok = r_in.receipt_complete && (r_in.receipt_signature == RECEIPT_SIG)
                        && (r_in.receipt_tag == r_pend_tag) && (r_in.receipt_status == 8'd0);

    always_comb begin
        res0           = '0;
        res1           = '0;
        res0.last_of_run = 1'b1;
        res1.last_of_run = 1'b1;
        two            = 1'b0;
        n_attached     = r_attached;
        n_tag_seq      = r_tag_seq;
        n_busy         = r_busy;
        n_pend_kind    = r_pend_kind;
        n_pend_tag     = r_pend_tag;
        n_sector_count = r_sector_count;
        n_sector_size  = r_sector_size;
        if (fire) begin
            unique case (r_in.req_type)
                REQ_RW: begin
                    if (!r_attached || r_busy || r_sector_count == 32'd0
                        || r_in.block_count == 32'd0 || r_in.block_count > 32'h0000_FFFF
                        || end_sum > {1'b0, r_sector_count}) begin
                        res0.result_kind = RES_REFUSED;
                    end else begin
                        res0.result_kind     = RES_ENVELOPE;
                        res0.env_tag         = r_tag_seq;
                        res0.env_data_length = 28'(prod);
                        res0.env_data_in     = !r_in.is_write;
                        res0.env_opcode      = r_in.is_write ? OP_WRITE10 : OP_READ10;
                        res0.env_block_addr  = r_in.block_addr;
                        res0.env_block_count = r_in.block_count[15:0];
                        res0.env_cmd_len     = CMD_LEN_10;
                        n_tag_seq   = r_tag_seq + 32'd1;
                        n_busy      = 1'b1;
                        n_pend_kind = PK_RW;
                        n_pend_tag  = r_tag_seq;
                    end
                end
                REQ_PROBE, REQ_CAPQUERY: begin
                    if (!r_attached || r_busy) begin
                        res0.result_kind = RES_REFUSED;
                    end else begin
                        res0.result_kind = RES_ENVELOPE;
                        res0.env_tag     = r_tag_seq;
                        n_tag_seq  = r_tag_seq + 32'd1;
                        n_busy     = 1'b1;
                        n_pend_tag = r_tag_seq;
                        if (r_in.req_type == REQ_PROBE) begin
                            res0.env_opcode  = OP_PROBE;
                            res0.env_cmd_len = CMD_LEN_6;
                            n_pend_kind      = PK_PROBE;
                        end else begin
                            res0.env_data_length = CAP_BYTES;
                            res0.env_data_in     = 1'b1;
                            res0.env_opcode      = OP_CAPACITY;
                            res0.env_cmd_len     = CMD_LEN_10;
                            n_pend_kind          = PK_CAP;
                        end
                    end
                end
                REQ_CAPREPLY: begin
                    if (!r_attached || !r_busy || r_pend_kind != PK_CAP
                        || r_in.reply_block_size == 32'd0
                        || r_in.reply_block_size > 32'(P_MAX_BLOCK_SIZE)
                        || r_in.reply_last_block == LAST_BLOCK_MAX) begin
                        res0.result_kind = RES_CAP_REFUSED;
                    end else begin
                        res0.result_kind = RES_CAP_TAKEN;
                        n_sector_count = r_in.reply_last_block + 32'd1;
                        n_sector_size  = r_in.reply_block_size[SW-1:0];
                    end
                end
                REQ_RECEIPT: begin
                    if (!r_busy) begin
                        res0.result_kind = RES_REFUSED;
                    end else begin
                        n_busy      = 1'b0;
                        n_pend_kind = PK_SENSE;
                        n_pend_tag  = 32'd0;
                        res0.env_tag = r_pend_tag;
                        if (receipt_ok) begin
                            res0.result_kind = RES_GOOD;
                        end else begin
                            res0.result_kind = RES_FAILED;
                            if ((r_pend_kind == PK_RW || r_pend_kind == PK_PROBE)
                                && r_attached) begin
                                two              = 1'b1;
                                res0.last_of_run = 1'b0;
                                res1.result_kind     = RES_ENVELOPE;
                                res1.env_tag         = r_tag_seq;
                                res1.env_data_length = SENSE_BYTES;
                                res1.env_data_in     = 1'b1;
                                res1.env_opcode      = OP_SENSE;
                                res1.env_cmd_len     = CMD_LEN_6;
                                n_tag_seq   = r_tag_seq + 32'd1;
                                n_busy      = 1'b1;
                                n_pend_kind = PK_SENSE;
                                n_pend_tag  = r_tag_seq;
                            end
                        end
                    end
                end
                default: begin
                    res0.result_kind = RES_REFUSED;
                end
            endcase
        end
        if (cfg_wr) begin
            n_attached     = i_pwdata[0];
            n_sector_count = 32'd0;
            n_sector_size  = SW'(SECTOR_SIZE_DEFAULT);
            n_busy         = 1'b0;
            n_pend_kind    = PK_SENSE;
            n_pend_tag     = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v         <= 1'b0;
            r_o_v          <= 1'b0;
            r_x_v          <= 1'b0;
            r_attached     <= 1'b0;
            r_tag_seq      <= 32'd1;
            r_busy         <= 1'b0;
            r_pend_kind    <= PK_SENSE;
            r_pend_tag     <= 32'd0;
            r_sector_count <= 32'd0;
            r_sector_size  <= SW'(SECTOR_SIZE_DEFAULT);
        end else begin
            r_attached     <= n_attached;
            r_tag_seq      <= n_tag_seq;
            r_busy         <= n_busy;
            r_pend_kind    <= n_pend_kind;
            r_pend_tag     <= n_pend_tag;
            r_sector_count <= n_sector_count;
            r_sector_size  <= n_sector_size;
            if (in_acc) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
            if (fire) begin
                r_o_v <= 1'b1;
                r_x_v <= two;
            end else if (r_x_v && slot_free) begin
                r_o_v <= 1'b1;
                r_x_v <= 1'b0;
            end else if (o_res.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.req_type          <= i_req.req_type;
            r_in.is_write          <= i_req.is_write;
            r_in.block_addr        <= i_req.block_addr;
            r_in.block_count       <= i_req.block_count;
            r_in.reply_last_block  <= i_req.reply_last_block;
            r_in.reply_block_size  <= i_req.reply_block_size;
            r_in.receipt_signature <= i_req.receipt_signature;
            r_in.receipt_tag       <= i_req.receipt_tag;
            r_in.receipt_status    <= i_req.receipt_status;
            r_in.receipt_complete  <= i_req.receipt_complete;
        end
        if (fire) begin
            r_o <= res0;
            r_x <= res1;
        end else if (r_x_v && slot_free) begin
            r_o <= r_x;
        end
    end

    assign o_res.valid           = r_o_v;
    assign o_res.result_kind     = r_o.result_kind;
    assign o_res.env_tag         = r_o.env_tag;
    assign o_res.env_data_length = r_o.env_data_length;
    assign o_res.env_data_in     = r_o.env_data_in;
    assign o_res.env_opcode      = r_o.env_opcode;
    assign o_res.env_block_addr  = r_o.env_block_addr;
    assign o_res.env_block_count = r_o.env_block_count;
    assign o_res.env_cmd_len     = r_o.env_cmd_len;
    assign o_res.last_of_run     = r_o.last_of_run;

endmodule

`default_nettype wire

// ----- hw/rtl/bot_checker.sv -----
// Port-level checks for the bulk-only transport command engine.
// Depends on bot_pkg; bound to usb_bulk_only_scsi_command_engine_top below.
`default_nettype none

module bot_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        i_ready,
    input wire [2:0]  i_kind,
    input wire [27:0] i_len,
    input wire [7:0]  i_opcode,
    input wire [4:0]  i_cmd_len,
    input wire        i_last,
    input wire [31:0] i_tag
);
    import bot_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_tag)
            && $stable(i_last))
        else $error("result beat changed while stalled");

    a_not_last_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_kind == RES_FAILED)
        else $error("non-final beat is not a failed verdict");

    a_sense_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> i_valid && i_kind == RES_ENVELOPE
            && i_opcode == OP_SENSE && i_last)
        else $error("failed verdict not followed by sense envelope");

    a_cmd_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == RES_ENVELOPE |-> i_cmd_len == CMD_LEN_6
            || i_cmd_len == CMD_LEN_10)
        else $error("bad command length");

    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != RES_ENVELOPE |-> i_opcode == 8'd0 && i_len == 28'd0
            && i_cmd_len == 5'd0)
        else $error("envelope fields set on non-envelope beat");

endmodule

bind usb_bulk_only_scsi_command_engine_top bot_checker u_bot_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_kind    (o_res.result_kind),
    .i_len     (o_res.env_data_length),
    .i_opcode  (o_res.env_opcode),
    .i_cmd_len (o_res.env_cmd_len),
    .i_last    (o_res.last_of_run),
    .i_tag     (o_res.env_tag)
);

`default_nettype wire
